// ----- sv/cpu8x_pkg.sv -----
// ----------------------------------------------------------------------------
// cpu8x_pkg
// shared types and constants of the 8-bit cpu execute unit
// ----------------------------------------------------------------------------
package cpu8x_pkg;

  localparam logic [15:0] STACK_BASE = 16'h0100;
  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  P_RESET    = 8'h24;

  // flag bit positions
  localparam int unsigned FC = 0;
  localparam int unsigned FZ = 1;
  localparam int unsigned FI = 2;
  localparam int unsigned FD = 3;
  localparam int unsigned FB = 4;
  localparam int unsigned FU = 5;
  localparam int unsigned FV = 6;
  localparam int unsigned FN = 7;

  typedef enum logic [6:0] {
    OP_ADC, OP_AND, OP_ASL_M, OP_ASL_A, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI,
    OP_BNE, OP_BPL, OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV,
    OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX,
    OP_INY, OP_JMP, OP_JSR, OP_LDA, OP_LDX, OP_LDY, OP_LSR_M, OP_LSR_A,
    OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_ROL_M, OP_ROL_A,
    OP_ROR_M, OP_ROR_A, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI,
    OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA,
    OP_ALR, OP_ANC, OP_DCP, OP_ISB, OP_LAX, OP_RLA, OP_RRA, OP_SAX,
    OP_SLO, OP_SRE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } fsm_e;

  typedef struct packed {
    logic        is_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
    logic        halted_out;
    logic [7:0]  flags_out;
    logic [7:0]  acc_out;
    logic        last;
  } res_t;

endpackage

// ----- sv/cpu8x_if.sv -----
// ----------------------------------------------------------------------------
// cpu8x_in_if / cpu8x_out_if
// valid/ready channels of the execute unit
// ----------------------------------------------------------------------------
interface cpu8x_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  op;
  logic [15:0] operand_address;
  logic [7:0]  operand_data;
  logic [15:0] pc_in;

  modport source (output valid, op, operand_address, operand_data, pc_in, input ready);
  modport sink   (input valid, op, operand_address, operand_data, pc_in, output ready);
endinterface

interface cpu8x_out_if;
  logic        valid;
  logic        ready;
  logic        is_write;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [15:0] next_pc;
  logic [1:0]  extra_cycles;
  logic        halted_out;
  logic [7:0]  flags_out;
  logic [7:0]  acc_out;
  logic        last;

  modport source (output valid, is_write, write_address, write_data, next_pc,
                  extra_cycles, halted_out, flags_out, acc_out, last, input ready);
  modport sink   (input valid, is_write, write_address, write_data, next_pc,
                  extra_cycles, halted_out, flags_out, acc_out, last, output ready);
endinterface

// ----- sv/cpu8_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// cpu8_instruction_execute
// execute unit of a 6502 style cpu: registers, flags, stack page mirror
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_i    | in  | one decoded instruction: op, operand address/data, pc
//  out_o   | out | up to two bus writes, then one status item (last=1)
//
//  an instruction emits one result transaction at a time (1 to 3), after
//  stack page reads for pulls (1 byte for PLA/PLP, 2 RTS, 3 RTI)
//  the two-port stack mirror, read one byte a cycle, sets the pull cost
//  the next instruction is taken in the cycle its predecessor's status leaves
//  a stalled output holds in the result register; reset clears all mirror
//  valid bits at once
// ----------------------------------------------------------------------------
module cpu8_instruction_execute (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpu8x_in_if.sink   in_i,
  cpu8x_out_if.source out_o
);

  // architectural state
  logic [7:0] a_q, x_q, y_q, s_q, p_q;
  logic       halt_q;

  // instruction register
  logic [6:0]  op_q;
  logic [15:0] addr_q, pc_q;
  logic [7:0]  data_q;

  // sequencer
  cpu8x_pkg::fsm_e state_q, state_d;
  logic [1:0] cnt_q, ph_q;
  logic [7:0] pb_q [3];

  // stack page mirror
  logic [7:0]   mem [256];
  logic [255:0] vld_q;
  logic [7:0]   rd_q;
  logic         rd_vld_q;
  logic [7:0]   rd_addr;
  logic [7:0]   rd_data;

  // output register
  cpu8x_pkg::res_t out_q, res;
  logic            out_vld_q;

  // execute results
  logic [7:0]  ex_a, ex_x, ex_y, ex_s, ex_p;
  logic        ex_halt;
  logic [15:0] ex_pc;
  logic [1:0]  ex_extra;
  logic [1:0]  ex_nwr;
  logic [15:0] wa0, wa1, wa_sel, rel;
  logic [7:0]  wd0, wd1;

  logic slot_free, emit, done, accept, halt_d, mem_we;
  logic [1:0] npull_cur, npull_new;

  // ---------------------------------------------------------------- helpers
  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    nz = {v[7], p[6:2], (v == 8'h00), p[0]};
  endfunction

  function automatic logic [15:0] adc(input logic [7:0] a, input logic [7:0] n,
                                      input logic [7:0] p);
    logic [8:0] sum;
    logic [7:0] q;
    sum = {1'b0, a} + {1'b0, n} + {8'h00, p[cpu8x_pkg::FC]};
    q = p;
    q[cpu8x_pkg::FV] = ~(a[7] ^ n[7]) & (a[7] ^ sum[7]);
    q[cpu8x_pkg::FC] = sum[8];
    adc = {nz(q, sum[7:0]), sum[7:0]};
  endfunction

  function automatic logic [7:0] cmpf(input logic [7:0] r, input logic [7:0] n,
                                      input logic [7:0] p);
    logic [8:0] sum;
    logic [7:0] q;
    sum = {1'b0, r} + {1'b0, ~n} + 9'd1;
    q = p;
    q[cpu8x_pkg::FC] = sum[8];
    cmpf = nz(q, sum[7:0]);
  endfunction

  // kind: 0 asl, 1 lsr, 2 rol, 3 ror; returns {flags, value}
  function automatic logic [15:0] shf(input logic [1:0] kind, input logic [7:0] n,
                                      input logic [7:0] p);
    logic [7:0] r, q;
    logic       co;
    unique case (kind)
      2'd0: begin r = {n[6:0], 1'b0};               co = n[7]; end
      2'd1: begin r = {1'b0, n[7:1]};               co = n[0]; end
      2'd2: begin r = {n[6:0], p[cpu8x_pkg::FC]};   co = n[7]; end
      default: begin r = {p[cpu8x_pkg::FC], n[7:1]}; co = n[0]; end
    endcase
    q = p;
    q[cpu8x_pkg::FC] = co;
    shf = {nz(q, r), r};
  endfunction

  function automatic logic [1:0] npull(input logic [6:0] op, input logic halted);
    if (halted) begin
      npull = 2'd0;
    end else begin
      unique case (op)
        cpu8x_pkg::OP_PLA, cpu8x_pkg::OP_PLP: npull = 2'd1;
        cpu8x_pkg::OP_RTS:                    npull = 2'd2;
        cpu8x_pkg::OP_RTI:                    npull = 2'd3;
        default:                              npull = 2'd0;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- execute
  always_comb begin
    logic [15:0] t;
    logic [15:0] ret;
    logic        br;
    ex_a = a_q; ex_x = x_q; ex_y = y_q; ex_s = s_q; ex_p = p_q;
    ex_halt = halt_q; ex_pc = pc_q; ex_extra = 2'd0; ex_nwr = 2'd0;
    wa0 = addr_q; wd0 = 8'h00; wa1 = 16'h0000; wd1 = 8'h00;
    br = 1'b0; t = 16'h0000;
    ret = pc_q - 16'd1;
    if (!halt_q) begin
      unique case (cpu8x_pkg::op_e'(op_q))
        cpu8x_pkg::OP_ADC: {ex_p, ex_a} = adc(a_q, data_q, p_q);
        cpu8x_pkg::OP_SBC: {ex_p, ex_a} = adc(a_q, ~data_q, p_q);
        cpu8x_pkg::OP_AND: begin ex_a = a_q & data_q; ex_p = nz(p_q, ex_a); end
        cpu8x_pkg::OP_EOR: begin ex_a = a_q ^ data_q; ex_p = nz(p_q, ex_a); end
        cpu8x_pkg::OP_ORA: begin ex_a = a_q | data_q; ex_p = nz(p_q, ex_a); end
        cpu8x_pkg::OP_ASL_M: begin {ex_p, wd0} = shf(2'd0, data_q, p_q); ex_nwr = 2'd1; end
        cpu8x_pkg::OP_LSR_M: begin {ex_p, wd0} = shf(2'd1, data_q, p_q); ex_nwr = 2'd1; end
        cpu8x_pkg::OP_ROL_M: begin {ex_p, wd0} = shf(2'd2, data_q, p_q); ex_nwr = 2'd1; end
        cpu8x_pkg::OP_ROR_M: begin {ex_p, wd0} = shf(2'd3, data_q, p_q); ex_nwr = 2'd1; end
        cpu8x_pkg::OP_ASL_A: {ex_p, ex_a} = shf(2'd0, a_q, p_q);
        cpu8x_pkg::OP_LSR_A: {ex_p, ex_a} = shf(2'd1, a_q, p_q);
        cpu8x_pkg::OP_ROL_A: {ex_p, ex_a} = shf(2'd2, a_q, p_q);
        cpu8x_pkg::OP_ROR_A: {ex_p, ex_a} = shf(2'd3, a_q, p_q);
        cpu8x_pkg::OP_BCC: br = ~p_q[cpu8x_pkg::FC];
        cpu8x_pkg::OP_BCS: br =  p_q[cpu8x_pkg::FC];
        cpu8x_pkg::OP_BEQ: br =  p_q[cpu8x_pkg::FZ];
        cpu8x_pkg::OP_BNE: br = ~p_q[cpu8x_pkg::FZ];
        cpu8x_pkg::OP_BMI: br =  p_q[cpu8x_pkg::FN];
        cpu8x_pkg::OP_BPL: br = ~p_q[cpu8x_pkg::FN];
        cpu8x_pkg::OP_BVC: br = ~p_q[cpu8x_pkg::FV];
        cpu8x_pkg::OP_BVS: br =  p_q[cpu8x_pkg::FV];
        cpu8x_pkg::OP_BIT: begin
          ex_p[cpu8x_pkg::FN] = data_q[7];
          ex_p[cpu8x_pkg::FV] = data_q[6];
          ex_p[cpu8x_pkg::FZ] = ((data_q & a_q) == 8'h00);
        end
        cpu8x_pkg::OP_BRK: ex_halt = 1'b1;
        cpu8x_pkg::OP_CLC: ex_p[cpu8x_pkg::FC] = 1'b0;
        cpu8x_pkg::OP_CLD: ex_p[cpu8x_pkg::FD] = 1'b0;
        cpu8x_pkg::OP_CLI: ex_p[cpu8x_pkg::FI] = 1'b0;
        cpu8x_pkg::OP_CLV: ex_p[cpu8x_pkg::FV] = 1'b0;
        cpu8x_pkg::OP_SEC: ex_p[cpu8x_pkg::FC] = 1'b1;
        cpu8x_pkg::OP_SED: ex_p[cpu8x_pkg::FD] = 1'b1;
        cpu8x_pkg::OP_SEI: ex_p[cpu8x_pkg::FI] = 1'b1;
        cpu8x_pkg::OP_CMP: ex_p = cmpf(a_q, data_q, p_q);
        cpu8x_pkg::OP_CPX: ex_p = cmpf(x_q, data_q, p_q);
        cpu8x_pkg::OP_CPY: ex_p = cmpf(y_q, data_q, p_q);
        cpu8x_pkg::OP_DEC: begin
          wd0 = data_q - 8'd1; ex_nwr = 2'd1; ex_p = nz(p_q, wd0);
        end
        cpu8x_pkg::OP_INC: begin
          wd0 = data_q + 8'd1; ex_nwr = 2'd1; ex_p = nz(p_q, wd0);
        end
        cpu8x_pkg::OP_DEX: begin ex_x = x_q - 8'd1; ex_p = nz(p_q, ex_x); end
        cpu8x_pkg::OP_DEY: begin ex_y = y_q - 8'd1; ex_p = nz(p_q, ex_y); end
        cpu8x_pkg::OP_INX: begin ex_x = x_q + 8'd1; ex_p = nz(p_q, ex_x); end
        cpu8x_pkg::OP_INY: begin ex_y = y_q + 8'd1; ex_p = nz(p_q, ex_y); end
        cpu8x_pkg::OP_JMP: ex_pc = addr_q;
        cpu8x_pkg::OP_JSR: begin
          wa0 = cpu8x_pkg::STACK_BASE + {8'h00, s_q};
          wd0 = ret[15:8];
          wa1 = cpu8x_pkg::STACK_BASE + {8'h00, s_q - 8'd1};
          wd1 = ret[7:0];
          ex_s = s_q - 8'd2; ex_pc = addr_q; ex_nwr = 2'd2;
        end
        cpu8x_pkg::OP_LDA: begin ex_a = data_q; ex_p = nz(p_q, data_q); end
        cpu8x_pkg::OP_LDX: begin ex_x = data_q; ex_p = nz(p_q, data_q); end
        cpu8x_pkg::OP_LDY: begin ex_y = data_q; ex_p = nz(p_q, data_q); end
        cpu8x_pkg::OP_PHA: begin
          wa0 = cpu8x_pkg::STACK_BASE + {8'h00, s_q}; wd0 = a_q;
          ex_s = s_q - 8'd1; ex_nwr = 2'd1;
        end
        cpu8x_pkg::OP_PHP: begin
          wa0 = cpu8x_pkg::STACK_BASE + {8'h00, s_q}; wd0 = p_q | 8'b0011_0000;
          ex_s = s_q - 8'd1; ex_nwr = 2'd1;
        end
        cpu8x_pkg::OP_PLA: begin
          ex_s = s_q + 8'd1; ex_a = pb_q[0]; ex_p = nz(p_q, pb_q[0]);
        end
        cpu8x_pkg::OP_PLP: begin
          ex_s = s_q + 8'd1;
          ex_p = (pb_q[0] & 8'b1100_1111) | (p_q & 8'b0001_0000) | 8'b0010_0000;
        end
        cpu8x_pkg::OP_RTI: begin
          ex_s = s_q + 8'd3;
          ex_p = (pb_q[0] & 8'b1100_1111) | (p_q & 8'b0001_0000) | 8'b0010_0000;
          ex_pc = {pb_q[2], pb_q[1]};
        end
        cpu8x_pkg::OP_RTS: begin
          ex_s = s_q + 8'd2; ex_pc = {pb_q[1], pb_q[0]} + 16'd1;
        end
        cpu8x_pkg::OP_STA: begin wd0 = a_q; ex_nwr = 2'd1; end
        cpu8x_pkg::OP_STX: begin wd0 = x_q; ex_nwr = 2'd1; end
        cpu8x_pkg::OP_STY: begin wd0 = y_q; ex_nwr = 2'd1; end
        cpu8x_pkg::OP_SAX: begin wd0 = a_q & x_q; ex_nwr = 2'd1; end
        cpu8x_pkg::OP_TAX: begin ex_x = a_q; ex_p = nz(p_q, a_q); end
        cpu8x_pkg::OP_TAY: begin ex_y = a_q; ex_p = nz(p_q, a_q); end
        cpu8x_pkg::OP_TSX: begin ex_x = s_q; ex_p = nz(p_q, s_q); end
        cpu8x_pkg::OP_TXA: begin ex_a = x_q; ex_p = nz(p_q, x_q); end
        cpu8x_pkg::OP_TXS: ex_s = x_q;
        cpu8x_pkg::OP_TYA: begin ex_a = y_q; ex_p = nz(p_q, y_q); end
        cpu8x_pkg::OP_ALR: {ex_p, ex_a} = shf(2'd1, a_q & data_q, p_q);
        cpu8x_pkg::OP_ANC: begin
          ex_a = a_q & data_q; ex_p = nz(p_q, ex_a);
          ex_p[cpu8x_pkg::FC] = ex_a[7];
        end
        cpu8x_pkg::OP_DCP: begin
          wd0 = data_q - 8'd1; ex_nwr = 2'd1; ex_p = cmpf(a_q, wd0, p_q);
        end
        cpu8x_pkg::OP_ISB: begin
          wd0 = data_q + 8'd1; ex_nwr = 2'd1; {ex_p, ex_a} = adc(a_q, ~wd0, p_q);
        end
        cpu8x_pkg::OP_LAX: begin
          ex_a = data_q; ex_x = data_q; ex_p = nz(p_q, data_q);
        end
        cpu8x_pkg::OP_RLA: begin
          t = shf(2'd2, data_q, p_q); wd0 = t[7:0]; ex_nwr = 2'd1;
          ex_a = a_q & t[7:0]; ex_p = nz(t[15:8], ex_a);
        end
        cpu8x_pkg::OP_RRA: begin
          t = shf(2'd3, data_q, p_q); wd0 = t[7:0]; ex_nwr = 2'd1;
          {ex_p, ex_a} = adc(a_q, t[7:0], t[15:8]);
        end
        cpu8x_pkg::OP_SLO: begin
          t = shf(2'd0, data_q, p_q); wd0 = t[7:0]; ex_nwr = 2'd1;
          ex_a = a_q | t[7:0]; ex_p = nz(t[15:8], ex_a);
        end
        cpu8x_pkg::OP_SRE: begin
          t = shf(2'd1, data_q, p_q); wd0 = t[7:0]; ex_nwr = 2'd1;
          ex_a = a_q ^ t[7:0]; ex_p = nz(t[15:8], ex_a);
        end
        default: ; // nop and unassigned codes
      endcase
      if (br) begin
        ex_extra = (addr_q[15:8] != pc_q[15:8]) ? 2'd2 : 2'd1;
        ex_pc = addr_q;
      end
    end
  end

  // ---------------------------------------------------------------- result select
  always_comb begin
    res = '0;
    if (ph_q < ex_nwr) begin
      res.is_write      = 1'b1;
      res.write_address = (ph_q == 2'd0) ? wa0 : wa1;
      res.write_data    = (ph_q == 2'd0) ? wd0 : wd1;
    end else begin
      res.next_pc      = ex_pc;
      res.extra_cycles = ex_extra;
      res.halted_out   = ex_halt;
      res.flags_out    = ex_p;
      res.acc_out      = ex_a;
      res.last         = 1'b1;
    end
  end

  // ---------------------------------------------------------------- control
  assign slot_free = !out_vld_q || out_o.ready;
  assign emit      = (state_q == cpu8x_pkg::ST_EMIT) && slot_free;
  assign done      = emit && res.last;
  assign in_i.ready = (state_q == cpu8x_pkg::ST_IDLE) || done;
  assign accept    = in_i.valid && in_i.ready;
  assign halt_d    = done ? ex_halt : halt_q;
  assign npull_cur = npull(op_q, halt_q);
  assign npull_new = npull(in_i.op, halt_d);

  // a write into the stack page also lands in the mirror
  assign wa_sel = res.write_address;
  assign rel    = wa_sel - cpu8x_pkg::STACK_BASE;
  assign mem_we = emit && res.is_write && (rel[15:8] == 8'h00);

  assign rd_addr = s_q + 8'd1 + {6'd0, cnt_q};
  assign rd_data = rd_vld_q ? rd_q : 8'h00;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpu8x_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (npull_new != 2'd0) ? cpu8x_pkg::ST_READ : cpu8x_pkg::ST_EMIT;
        end
      end
      cpu8x_pkg::ST_READ: begin
        if (cnt_q == npull_cur) state_d = cpu8x_pkg::ST_EMIT;
      end
      cpu8x_pkg::ST_EMIT: begin
        if (done) begin
          if (accept) begin
            state_d = (npull_new != 2'd0) ? cpu8x_pkg::ST_READ : cpu8x_pkg::ST_EMIT;
          end else begin
            state_d = cpu8x_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = cpu8x_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpu8x_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      ph_q  <= 2'd0;
    end else begin
      if (accept) begin
        cnt_q <= 2'd0;
        ph_q  <= 2'd0;
      end else begin
        if (state_q == cpu8x_pkg::ST_READ) cnt_q <= cnt_q + 2'd1;
        if (emit) ph_q <= ph_q + 2'd1;
      end
    end
  end

  // instruction register and pulled bytes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.op;
      addr_q <= in_i.operand_address;
      data_q <= in_i.operand_data;
      pc_q   <= in_i.pc_in;
    end
    if ((state_q == cpu8x_pkg::ST_READ) && (cnt_q != 2'd0)) begin
      pb_q[cnt_q - 2'd1] <= rd_data;
    end
  end

  // architectural registers commit with the status item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= 8'h00;
      x_q    <= 8'h00;
      y_q    <= 8'h00;
      s_q    <= cpu8x_pkg::SP_RESET;
      p_q    <= cpu8x_pkg::P_RESET;
      halt_q <= 1'b0;
    end else if (done) begin
      a_q    <= ex_a;
      x_q    <= ex_x;
      y_q    <= ex_y;
      s_q    <= ex_s;
      p_q    <= ex_p;
      halt_q <= ex_halt;
    end
  end

  // stack mirror: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[rel[7:0]] <= res.write_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[rel[7:0]] <= 1'b1;
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_free) begin
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.is_write      = out_q.is_write;
  assign out_o.write_address = out_q.write_address;
  assign out_o.write_data    = out_q.write_data;
  assign out_o.next_pc       = out_q.next_pc;
  assign out_o.extra_cycles  = out_q.extra_cycles;
  assign out_o.halted_out    = out_q.halted_out;
  assign out_o.flags_out     = out_q.flags_out;
  assign out_o.acc_out       = out_q.acc_out;
  assign out_o.last          = out_q.last;

endmodule

// ----- sv/cpu8x_checker.sv -----
// ----------------------------------------------------------------------------
// cpu8x_checker
// port-level checks of the execute unit's result channel
// ----------------------------------------------------------------------------
module cpu8x_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        is_write_i,
  input logic        last_i,
  input logic [15:0] next_pc_i,
  input logic [7:0]  flags_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  // every result is either a bus write or the status item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (is_write_i != last_i))
    else $error("result is neither write nor status");

  // write items carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && is_write_i |-> (next_pc_i == 16'h0000) && (flags_i == 8'h00))
    else $error("write item carries status fields");

  // the unused flag bit always reads one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |-> flags_i[5])
    else $error("flag bit 5 clear in status");

endmodule

bind cpu8_instruction_execute cpu8x_checker u_cpu8x_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (out_o.valid),
  .ready_i    (out_o.ready),
  .is_write_i (out_o.is_write),
  .last_i     (out_o.last),
  .next_pc_i  (out_o.next_pc),
  .flags_i    (out_o.flags_out)
);

// ----- verif/cpu8x_tb_if.sv -----
// ----------------------------------------------------------------------------
// cpu8x_tb_if
// note: the valid/ready channels come from the rtl interface file
// ----------------------------------------------------------------------------
package cpu8x_tb_pkg;

  typedef struct {
    logic [6:0]  op;
    logic [15:0] operand_address;
    logic [7:0]  operand_data;
    logic [15:0] pc_in;
  } instr_t;
endpackage

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the 6502 style execute unit against an internal instruction model:
// directed corner instructions, one of each opcode but brk, then random
// programs with random idling on both channels and one long output stall
// ----------------------------------------------------------------------------
module testbench;

  logic clk_i;
  logic rst_ni;

  cpu8x_in_if  in_ch ();
  cpu8x_out_if out_ch ();

  cpu8_instruction_execute i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // model state of the cpu
  logic [7:0] m_a, m_x, m_y, m_s, m_p;
  logic       m_halt;
  logic [7:0] m_stack [256];

  cpu8x_tb_pkg::instr_t pending_instrs [$];
  cpu8x_pkg::res_t      expected_results [$];
  int     mismatches;
  int     cycle_count;
  logic   stim_done;
  int     in_wait, out_wait;
  int     hold_off;
  logic   hold_done;
  logic   hold_active;
  int     accepted;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic void emit_write(input logic [15:0] addr, input logic [7:0] data);
    cpu8x_pkg::res_t r;
    logic [15:0] rel;
    r = '0;
    rel = addr - cpu8x_pkg::STACK_BASE;
    if (rel < 16'd256) m_stack[rel[7:0]] = data;
    r.is_write = 1'b1;
    r.write_address = addr;
    r.write_data = data;
    expected_results.push_back(r);
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    emit_write(cpu8x_pkg::STACK_BASE + {8'h00, m_s}, v);
    m_s = m_s - 8'd1;
  endfunction

  function automatic logic [7:0] pull_byte();
    m_s = m_s + 8'd1;
    return m_stack[m_s];
  endfunction

  function automatic void set_nz(input logic [7:0] v);
    m_p[cpu8x_pkg::FN] = v[7];
    m_p[cpu8x_pkg::FZ] = (v == 8'h00);
  endfunction

  function automatic void add_acc(input logic [7:0] n);
    logic [8:0] sum;
    sum = {1'b0, m_a} + {1'b0, n} + {8'h00, m_p[cpu8x_pkg::FC]};
    m_p[cpu8x_pkg::FV] = ~(m_a[7] ^ n[7]) & (m_a[7] ^ sum[7]);
    m_p[cpu8x_pkg::FC] = sum[8];
    m_a = sum[7:0];
    set_nz(m_a);
  endfunction

  function automatic void cmp_reg(input logic [7:0] r, input logic [7:0] n);
    logic [8:0] d;
    d = {1'b0, r} + {1'b0, ~n} + 9'd1;
    m_p[cpu8x_pkg::FC] = d[8];
    set_nz(d[7:0]);
  endfunction

  // kind: 0 asl, 1 lsr, 2 rol, 3 ror
  function automatic logic [7:0] shift_byte(input int kind, input logic [7:0] n);
    logic [7:0] r;
    case (kind)
      0: r = {n[6:0], 1'b0};
      1: r = {1'b0, n[7:1]};
      2: r = {n[6:0], m_p[cpu8x_pkg::FC]};
      default: r = {m_p[cpu8x_pkg::FC], n[7:1]};
    endcase
    m_p[cpu8x_pkg::FC] = (kind == 0 || kind == 2) ? n[7] : n[0];
    set_nz(r);
    return r;
  endfunction

  function automatic void pull_flags();
    logic [7:0] v;
    v = pull_byte();
    m_p = (v & 8'hCF) | (m_p & 8'h10) | 8'h20;
  endfunction

  // executes one instruction and queues its writes and status
  function automatic void execute_instr(input cpu8x_tb_pkg::instr_t it);
    logic [15:0] pc, addr, ret;
    logic [7:0]  d, v, lo, hi;
    logic [1:0]  extra;
    int          take;
    cpu8x_pkg::res_t st;
    pc = it.pc_in; addr = it.operand_address; d = it.operand_data;
    extra = 2'd0; take = -1;
    if (!m_halt) begin
      case (it.op)
        cpu8x_pkg::OP_ADC:   add_acc(d);
        cpu8x_pkg::OP_AND:   begin m_a &= d; set_nz(m_a); end
        cpu8x_pkg::OP_ASL_M: emit_write(addr, shift_byte(0, d));
        cpu8x_pkg::OP_ASL_A: m_a = shift_byte(0, m_a);
        cpu8x_pkg::OP_BCC:   take = !m_p[cpu8x_pkg::FC];
        cpu8x_pkg::OP_BCS:   take = m_p[cpu8x_pkg::FC];
        cpu8x_pkg::OP_BEQ:   take = m_p[cpu8x_pkg::FZ];
        cpu8x_pkg::OP_BIT:   begin
          m_p[cpu8x_pkg::FN] = d[7];
          m_p[cpu8x_pkg::FV] = d[6];
          m_p[cpu8x_pkg::FZ] = ((d & m_a) == 0);
        end
        cpu8x_pkg::OP_BMI:   take = m_p[cpu8x_pkg::FN];
        cpu8x_pkg::OP_BNE:   take = !m_p[cpu8x_pkg::FZ];
        cpu8x_pkg::OP_BPL:   take = !m_p[cpu8x_pkg::FN];
        cpu8x_pkg::OP_BRK:   m_halt = 1'b1;
        cpu8x_pkg::OP_BVC:   take = !m_p[cpu8x_pkg::FV];
        cpu8x_pkg::OP_BVS:   take = m_p[cpu8x_pkg::FV];
        cpu8x_pkg::OP_CLC:   m_p[cpu8x_pkg::FC] = 1'b0;
        cpu8x_pkg::OP_CLD:   m_p[cpu8x_pkg::FD] = 1'b0;
        cpu8x_pkg::OP_CLI:   m_p[cpu8x_pkg::FI] = 1'b0;
        cpu8x_pkg::OP_CLV:   m_p[cpu8x_pkg::FV] = 1'b0;
        cpu8x_pkg::OP_CMP:   cmp_reg(m_a, d);
        cpu8x_pkg::OP_CPX:   cmp_reg(m_x, d);
        cpu8x_pkg::OP_CPY:   cmp_reg(m_y, d);
        cpu8x_pkg::OP_DEC:   begin v = d - 8'd1; emit_write(addr, v); set_nz(v); end
        cpu8x_pkg::OP_DEX:   begin m_x -= 8'd1; set_nz(m_x); end
        cpu8x_pkg::OP_DEY:   begin m_y -= 8'd1; set_nz(m_y); end
        cpu8x_pkg::OP_EOR:   begin m_a ^= d; set_nz(m_a); end
        cpu8x_pkg::OP_INC:   begin v = d + 8'd1; emit_write(addr, v); set_nz(v); end
        cpu8x_pkg::OP_INX:   begin m_x += 8'd1; set_nz(m_x); end
        cpu8x_pkg::OP_INY:   begin m_y += 8'd1; set_nz(m_y); end
        cpu8x_pkg::OP_JMP:   pc = addr;
        cpu8x_pkg::OP_JSR:   begin
          ret = pc - 16'd1;
          push_byte(ret[15:8]);
          push_byte(ret[7:0]);
          pc = addr;
        end
        cpu8x_pkg::OP_LDA:   begin m_a = d; set_nz(d); end
        cpu8x_pkg::OP_LDX:   begin m_x = d; set_nz(d); end
        cpu8x_pkg::OP_LDY:   begin m_y = d; set_nz(d); end
        cpu8x_pkg::OP_LSR_M: emit_write(addr, shift_byte(1, d));
        cpu8x_pkg::OP_LSR_A: m_a = shift_byte(1, m_a);
        cpu8x_pkg::OP_ORA:   begin m_a |= d; set_nz(m_a); end
        cpu8x_pkg::OP_PHA:   push_byte(m_a);
        cpu8x_pkg::OP_PHP:   push_byte(m_p | 8'h30);
        cpu8x_pkg::OP_PLA:   begin m_a = pull_byte(); set_nz(m_a); end
        cpu8x_pkg::OP_PLP:   pull_flags();
        cpu8x_pkg::OP_ROL_M: emit_write(addr, shift_byte(2, d));
        cpu8x_pkg::OP_ROL_A: m_a = shift_byte(2, m_a);
        cpu8x_pkg::OP_ROR_M: emit_write(addr, shift_byte(3, d));
        cpu8x_pkg::OP_ROR_A: m_a = shift_byte(3, m_a);
        cpu8x_pkg::OP_RTI:   begin
          pull_flags(); lo = pull_byte(); hi = pull_byte(); pc = {hi, lo};
        end
        cpu8x_pkg::OP_RTS:   begin
          lo = pull_byte(); hi = pull_byte(); pc = {hi, lo} + 16'd1;
        end
        cpu8x_pkg::OP_SBC:   add_acc(~d);
        cpu8x_pkg::OP_SEC:   m_p[cpu8x_pkg::FC] = 1'b1;
        cpu8x_pkg::OP_SED:   m_p[cpu8x_pkg::FD] = 1'b1;
        cpu8x_pkg::OP_SEI:   m_p[cpu8x_pkg::FI] = 1'b1;
        cpu8x_pkg::OP_STA:   emit_write(addr, m_a);
        cpu8x_pkg::OP_STX:   emit_write(addr, m_x);
        cpu8x_pkg::OP_STY:   emit_write(addr, m_y);
        cpu8x_pkg::OP_TAX:   begin m_x = m_a; set_nz(m_x); end
        cpu8x_pkg::OP_TAY:   begin m_y = m_a; set_nz(m_y); end
        cpu8x_pkg::OP_TSX:   begin m_x = m_s; set_nz(m_x); end
        cpu8x_pkg::OP_TXA:   begin m_a = m_x; set_nz(m_a); end
        cpu8x_pkg::OP_TXS:   m_s = m_x;
        cpu8x_pkg::OP_TYA:   begin m_a = m_y; set_nz(m_a); end
        cpu8x_pkg::OP_ALR:   begin m_a &= d; m_a = shift_byte(1, m_a); end
        cpu8x_pkg::OP_ANC:   begin m_a &= d; set_nz(m_a); m_p[cpu8x_pkg::FC] = m_a[7]; end
        cpu8x_pkg::OP_DCP:   begin v = d - 8'd1; emit_write(addr, v); cmp_reg(m_a, v); end
        cpu8x_pkg::OP_ISB:   begin v = d + 8'd1; emit_write(addr, v); add_acc(~v); end
        cpu8x_pkg::OP_LAX:   begin m_a = d; m_x = d; set_nz(d); end
        cpu8x_pkg::OP_RLA:   begin
          v = shift_byte(2, d); emit_write(addr, v); m_a &= v; set_nz(m_a);
        end
        cpu8x_pkg::OP_RRA:   begin v = shift_byte(3, d); emit_write(addr, v); add_acc(v); end
        cpu8x_pkg::OP_SAX:   emit_write(addr, m_a & m_x);
        cpu8x_pkg::OP_SLO:   begin
          v = shift_byte(0, d); emit_write(addr, v); m_a |= v; set_nz(m_a);
        end
        cpu8x_pkg::OP_SRE:   begin
          v = shift_byte(1, d); emit_write(addr, v); m_a ^= v; set_nz(m_a);
        end
        default: ;  // nop and unknown codes
      endcase
      if (take == 1) begin
        extra = (addr[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
        pc = addr;
      end
    end
    st = '0;
    st.next_pc = pc;
    st.extra_cycles = extra;
    st.halted_out = m_halt;
    st.flags_out = m_p;
    st.acc_out = m_a;
    st.last = 1'b1;
    expected_results.push_back(st);
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic void add_instr(input logic [6:0] op, input logic [15:0] addr,
                                    input logic [7:0] d, input logic [15:0] pc);
    cpu8x_tb_pkg::instr_t it;
    it.op = op; it.operand_address = addr; it.operand_data = d; it.pc_in = pc;
    pending_instrs.push_back(it);
  endfunction

  // random op, now and then an unassigned code; never brk so the cpu keeps running
  function automatic logic [6:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 7'($urandom_range(70, 127));
    if (r < 12) begin
      case ($urandom_range(0, 5))
        0: return cpu8x_pkg::OP_PHA;
        1: return cpu8x_pkg::OP_PLA;
        2: return cpu8x_pkg::OP_PHP;
        3: return cpu8x_pkg::OP_PLP;
        4: return cpu8x_pkg::OP_JSR;
        default: return cpu8x_pkg::OP_RTS;
      endcase
    end
    do r = $urandom_range(0, 69); while (r == cpu8x_pkg::OP_BRK);
    return 7'(r);
  endfunction

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return cpu8x_pkg::STACK_BASE + 16'($urandom_range(0, 255));
      1: return 16'hFFFF * 16'($urandom_range(0, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] pc;
    stim_done = 1'b0;
    // directed: extremes, stack round trips, flag pulls, branches across pages
    add_instr(cpu8x_pkg::OP_LDA, 16'h0000, 8'hFF, 16'h0200);
    add_instr(cpu8x_pkg::OP_ADC, 16'hFFFF, 8'h01, 16'h0202);   // carry out and zero
    add_instr(cpu8x_pkg::OP_ADC, 16'h0000, 8'h7F, 16'h0204);   // signed overflow
    add_instr(cpu8x_pkg::OP_SBC, 16'h0000, 8'h80, 16'h0206);
    add_instr(cpu8x_pkg::OP_BCC, 16'h0300, 8'h00, 16'h02FE);
    add_instr(cpu8x_pkg::OP_BCS, 16'h02F0, 8'h00, 16'h0280);
    add_instr(cpu8x_pkg::OP_PHP, 16'h0000, 8'h00, 16'h0300);
    add_instr(cpu8x_pkg::OP_LDA, 16'h0000, 8'hFF, 16'h0301);
    add_instr(cpu8x_pkg::OP_PHA, 16'h0000, 8'h00, 16'h0302);
    add_instr(cpu8x_pkg::OP_PLP, 16'h0000, 8'h00, 16'h0303);   // pulled byte bits 4,5 ignored
    add_instr(cpu8x_pkg::OP_PLP, 16'h0000, 8'h00, 16'h0304);
    add_instr(cpu8x_pkg::OP_JSR, 16'hFFFF, 8'h00, 16'h0000);   // return address wraps
    add_instr(cpu8x_pkg::OP_RTS, 16'h0000, 8'h00, 16'h1234);
    add_instr(cpu8x_pkg::OP_STA, 16'h01FF, 8'h00, 16'h0400);   // write into stack page
    add_instr(cpu8x_pkg::OP_TXS, 16'h0000, 8'h00, 16'h0401);   // stack pointer to zero
    add_instr(cpu8x_pkg::OP_PHA, 16'h0000, 8'h00, 16'h0402);   // pointer wraps down
    add_instr(cpu8x_pkg::OP_RTI, 16'h0000, 8'h00, 16'h0403);
    add_instr(cpu8x_pkg::OP_ANC, 16'h0000, 8'h80, 16'h0404);
    add_instr(cpu8x_pkg::OP_RRA, 16'h0100, 8'hFF, 16'h0405);
    add_instr(cpu8x_pkg::OP_ISB, 16'hFFFF, 8'hFF, 16'h0406);
    add_instr(cpu8x_pkg::OP_DCP, 16'h0000, 8'h00, 16'h0407);
    add_instr(cpu8x_pkg::OP_SAX, 16'hABCD, 8'h00, 16'hFFFF);
    add_instr(7'h7F, 16'hFFFF, 8'hFF, 16'hFFFF);   // unknown code acts as nop
    for (int i = 0; i <= 69; i++) begin
      if (i != cpu8x_pkg::OP_BRK)
        add_instr(7'(i), rand_addr(), 8'($urandom), 16'($urandom));
    end
    pc = 16'($urandom);
    for (int i = 0; i < 180; i++) begin
      if ($urandom_range(0, 9) == 0) pc = 16'($urandom);
      add_instr(rand_op(), rand_addr(), 8'($urandom), pc);
      pc = pc + 16'($urandom_range(1, 3));
    end
    // brk halts; further instructions only report status
    add_instr(cpu8x_pkg::OP_BRK, 16'h0000, 8'h00, 16'h8000);
    for (int i = 0; i < 6; i++) add_instr(rand_op(), rand_addr(), 8'($urandom), 16'($urandom));
    stim_done = 1'b1;
  end

  // ------------------------------------------------------------ driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= '0;
      in_ch.operand_address <= '0;
      in_ch.operand_data <= '0;
      in_ch.pc_in <= '0;
      in_wait <= 0;
      accepted <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted <= accepted + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // keep offering the same transaction
      end else if (in_wait > 0) begin
        in_ch.valid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (pending_instrs.size() > 0) begin
        cpu8x_tb_pkg::instr_t it;
        it = pending_instrs.pop_front();
        execute_instr(it);
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.operand_address <= it.operand_address;
        in_ch.operand_data <= it.operand_data;
        in_ch.pc_in <= it.pc_in;
        in_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ long stall

  // one long output stall once 60 instructions are accepted so the input backs up
  assign hold_active = !hold_done && (accepted >= 60);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 0;
      hold_done <= 1'b0;
    end else if (hold_active) begin
      if (hold_off >= 300) hold_done <= 1'b1;
      hold_off <= hold_off + 1;
    end
  end

  // ------------------------------------------------------------ monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
      mismatches <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        cpu8x_pkg::res_t got, exp_r;
        got.is_write = out_ch.is_write;
        got.write_address = out_ch.write_address;
        got.write_data = out_ch.write_data;
        got.next_pc = out_ch.next_pc;
        got.extra_cycles = out_ch.extra_cycles;
        got.halted_out = out_ch.halted_out;
        got.flags_out = out_ch.flags_out;
        got.acc_out = out_ch.acc_out;
        got.last = out_ch.last;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction %h", got);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            if (mismatches < 10)
              $display({"mismatch: expected w=%b a=%h d=%h pc=%h x=%0d h=%b p=%h acc=%h",
                        " l=%b, got w=%b a=%h d=%h pc=%h x=%0d h=%b p=%h acc=%h l=%b"},
                       exp_r.is_write, exp_r.write_address, exp_r.write_data,
                       exp_r.next_pc, exp_r.extra_cycles, exp_r.halted_out,
                       exp_r.flags_out, exp_r.acc_out, exp_r.last,
                       got.is_write, got.write_address, got.write_data, got.next_pc,
                       got.extra_cycles, got.halted_out, got.flags_out, got.acc_out,
                       got.last);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (hold_active) begin
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        out_wait <= out_wait - 1;
      end else if (out_ch.valid && out_ch.ready) begin
        if ($urandom_range(0, 2) != 0) begin
          out_ch.ready <= 1'b0;
          out_wait <= $urandom_range(0, 19);
        end
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ run control

  initial begin
    int drain;
    cycle_count = 0;
    drain = 0;
    m_a = '0; m_x = '0; m_y = '0;
    m_s = cpu8x_pkg::SP_RESET; m_p = cpu8x_pkg::P_RESET; m_halt = 1'b0;
    foreach (m_stack[i]) m_stack[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("[cpu8_instruction_execute] ERROR");
        $finish;
      end
      if (stim_done && pending_instrs.size() == 0 && !in_ch.valid &&
          expected_results.size() == 0)
        drain++;
      else
        drain = 0;
      if (drain > 20) begin
        if (mismatches == 0)
          $display("[cpu8_instruction_execute] OK");
        else
          $display("[cpu8_instruction_execute] ERROR");
        $finish;
      end
    end
  end

endmodule
